@@ src/utf8v_pkg.sv @@
// Shared types and constants for the UTF-8 validator.
// Used by the step logic, the result register, the top level and the checker.
package utf8v_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int COUNT_W = 25;
  localparam int LIMIT_W = 24;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd65536;

  localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF4;
  localparam logic [1:0]        CONT_TAG  = 2'b10;

  localparam logic [CP_W-1:0] MIN_3BYTE     = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4BYTE     = 21'h010000;
  localparam logic [CP_W-1:0] SURROGATE_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURROGATE_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MAX_CODEPOINT = 21'h10FFFF;

  localparam logic [2:0] SEQ_W1 = 3'd1;
  localparam logic [2:0] SEQ_W2 = 3'd2;
  localparam logic [2:0] SEQ_W3 = 3'd3;
  localparam logic [2:0] SEQ_W4 = 3'd4;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_t;

  // Decoder state carried from one byte to the next within a string.
  typedef struct packed {
    logic [1:0]         pending;
    logic [2:0]         seq_width;
    logic [CP_W-1:0]    partial;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } dec_state_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

@@ src/utf8_validator_with_codepoint_limit.sv @@
// UTF-8 validator with a codepoint limit: input register, step logic, result register.
// Depends on utf8v_pkg, utf8v_step and utf8v_out_reg.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one string byte per beat with
//   byte_present and last. A beat with byte_present low carries no byte; with
//   last high it closes the string, so on its own it reports an empty string.
//   The output channel (out_valid/out_ready) gives one beat per string, at its
//   last item: status (0 valid, 1 invalid encoding, 2 too many codepoints) and
//   codepoint_count. The configuration channel (cfg_valid/cfg_ready) writes
//   max_codepoints; it is always ready and should be written between strings.
//   The last beat passes from the input register through the decode step into
//   the result register, whose valid flag drives out_valid.
//   Throughput: one beat per cycle while no final beat waits for a full result
//   register; the decode step between the input register and the result register is combinational.
//   When the receiver stalls, the finished result waits in the result register
//   while non-final beats keep flowing; a second final beat waits in the input
//   register, after which in_ready drops.
//   Reset clears both registers' valid flags and the string state, and sets
//   max_codepoints to 65536.
module utf8_validator_with_codepoint_limit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [utf8v_pkg::BYTE_W-1:0]         data_byte,
  input  logic                                 byte_present,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic [utf8v_pkg::COUNT_W-1:0]        codepoint_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [utf8v_pkg::LIMIT_W-1:0]        max_codepoints
);
  import utf8v_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_present;
  logic              s1_last;
  logic              s1_go;
  logic              slot_free;

  logic [LIMIT_W-1:0] limit;
  dec_state_t         state;
  dec_state_t         state_next;
  result_t            step_res;
  result_t            res_out;

  // A non-final beat never needs the result slot, so it can always move on.
  assign s1_go     = s1_valid && (!s1_last || slot_free);
  assign in_ready  = !s1_valid || s1_go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte    <= data_byte;
      s1_present <= byte_present;
      s1_last    <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= max_codepoints;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{pending: 2'd0, seq_width: 3'd0, partial: '0, count: '0, status: ST_VALID};
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  utf8v_step u_step (
    .cur          (state),
    .data_byte    (s1_byte),
    .byte_present (s1_present),
    .last         (s1_last),
    .limit        (limit),
    .nxt          (state_next),
    .res          (step_res)
  );

  utf8v_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go && s1_last),
    .res_in    (step_res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign status          = res_out.status;
  assign codepoint_count = res_out.count;

endmodule

@@ src/utf8v_step.sv @@
// Next-state logic of the validator: decodes one byte against the string state.
// Depends on utf8v_pkg.
module utf8v_step (
  input  utf8v_pkg::dec_state_t                 cur,
  input  logic [utf8v_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                  byte_present,
  input  logic                                  last,
  input  logic [utf8v_pkg::LIMIT_W-1:0]         limit,
  output utf8v_pkg::dec_state_t                 nxt,
  output utf8v_pkg::result_t                    res
);
  import utf8v_pkg::*;

  dec_state_t         upd;
  logic [CP_W-1:0]    cp_shift;
  logic [1:0]         pend_dec;
  logic [COUNT_W-1:0] count_inc;
  logic               complete;
  logic               range_bad;

  assign cp_shift  = {cur.partial[CP_W-7:0], data_byte[5:0]};
  assign pend_dec  = cur.pending - 2'd1;
  assign count_inc = cur.count + COUNT_W'(1);

  assign range_bad = (cur.seq_width == SEQ_W3 && cp_shift < MIN_3BYTE) ||
                     (cur.seq_width == SEQ_W4 && cp_shift < MIN_4BYTE) ||
                     (cp_shift >= SURROGATE_LO && cp_shift <= SURROGATE_HI) ||
                     (cp_shift > MAX_CODEPOINT);

  always_comb begin
    upd      = cur;
    complete = 1'b0;
    if (byte_present && cur.status == ST_VALID) begin
      if (cur.pending == 2'd0) begin
        priority if (data_byte[7] == 1'b0) begin
          complete = 1'b1;
        end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
          upd.seq_width = SEQ_W2;
          upd.pending   = 2'd1;
          upd.partial   = CP_W'(data_byte[4:0]);
        end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
          upd.seq_width = SEQ_W3;
          upd.pending   = 2'd2;
          upd.partial   = CP_W'(data_byte[3:0]);
        end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
          upd.seq_width = SEQ_W4;
          upd.pending   = 2'd3;
          upd.partial   = CP_W'(data_byte[2:0]);
        end else begin
          upd.status = ST_INVALID;
        end
      end else if (data_byte[7:6] != CONT_TAG) begin
        upd.status = ST_INVALID;
      end else begin
        upd.partial = cp_shift;
        upd.pending = pend_dec;
        if (pend_dec == 2'd0) begin
          if (range_bad) begin
            upd.status = ST_INVALID;
          end else begin
            complete = 1'b1;
          end
        end
      end
    end
    // A completed codepoint is checked against the limit as it is counted.
    if (complete) begin
      upd.count     = count_inc;
      upd.seq_width = 3'd0;
      upd.partial   = '0;
      if (count_inc > {1'b0, limit}) begin
        upd.status = ST_TOO_MANY;
      end
    end

    // A sequence cut short by the end of the string is invalid.
    res.count  = upd.count;
    res.status = upd.status;
    if (upd.status == ST_VALID && upd.pending != 2'd0) begin
      res.status = ST_INVALID;
    end

    if (last) begin
      nxt = '{pending: 2'd0, seq_width: 3'd0, partial: '0, count: '0, status: ST_VALID};
    end else begin
      nxt = upd;
    end
  end

endmodule

@@ src/utf8v_out_reg.sv @@
// Result register of the validator: holds one finished result until it is taken.
// Depends on utf8v_pkg.
module utf8v_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  utf8v_pkg::result_t  res_in,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output utf8v_pkg::result_t  res_out
);
  import utf8v_pkg::*;

  result_t held;
  logic    valid;

  assign slot_free = !valid || out_ready;
  assign out_valid = valid;
  assign res_out   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

endmodule

@@ src/utf8v_checker.sv @@
// Port-level checks for the UTF-8 validator, bound to the top level.
// Depends on utf8v_pkg.
module utf8v_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [utf8v_pkg::BYTE_W-1:0]     data_byte,
  input logic                             byte_present,
  input logic                             last,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       status,
  input logic [utf8v_pkg::COUNT_W-1:0]    codepoint_count,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [utf8v_pkg::LIMIT_W-1:0]    max_codepoints
);
  import utf8v_pkg::*;

  // No result may be pending in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_VALID || status == ST_INVALID || status == ST_TOO_MANY))
    else $error("undefined status code");

  // A valid string holds at most the largest limit, which fits in 24 bits.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_VALID |-> !codepoint_count[COUNT_W-1])
    else $error("valid string reports a count above any limit");

  // Exceeding the limit needs at least one completed codepoint.
  a_over_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TOO_MANY |-> codepoint_count != '0)
    else $error("too-many status with zero count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(codepoint_count))
    else $error("stalled result beat changed");

endmodule

bind utf8_validator_with_codepoint_limit utf8v_checker u_chk (.*);

@@ dv/tb_utf8_validator_with_codepoint_limit.sv @@
// Testbench for utf8_validator_with_codepoint_limit: directed and random UTF-8 strings.
// Depends on utf8v_pkg and the validator RTL. A built-in predictor checks every verdict.
module tb_utf8_validator_with_codepoint_limit;
  import utf8v_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 6;

  typedef struct {
    logic [BYTE_W-1:0] data;
    bit                present;
    bit                fin;
  } beat_t;

  // Decodes accepted beats the way the block should and queues one verdict per string.
  class utf8_verdicts;
    logic [LIMIT_W-1:0] limit;
    logic [1:0]         pending;
    logic [2:0]         seq_len;
    logic [20:0]        partial;
    logic [COUNT_W-1:0] count;
    status_t            state;
    result_t            expected[$];
    int                 errors;
    int                 checked;
    int                 n_valid;
    int                 n_invalid;
    int                 n_too_many;

    function new();
      limit = 24'd65536;
      errors = 0;
      checked = 0;
      n_valid = 0;
      n_invalid = 0;
      n_too_many = 0;
      clear_string();
    endfunction

    function void clear_string();
      pending = 2'd0;
      seq_len = 3'd0;
      partial = 21'd0;
      count = '0;
      state = ST_VALID;
    endfunction

    // The limit is compared at every completion, so the count can pass it only once.
    function void count_codepoint();
      count = count + COUNT_W'(1);
      if (count > {1'b0, limit}) state = ST_TOO_MANY;
      seq_len = 3'd0;
      partial = 21'd0;
    endfunction

    function void take_beat(logic [BYTE_W-1:0] b, bit present, bit fin);
      result_t verdict;
      if (present && state == ST_VALID) begin
        if (pending == 2'd0) begin
          if (b <= 8'h7F) begin
            seq_len = 3'd1;
            partial = {13'd0, b};
            count_codepoint();
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            seq_len = 3'd2;
            pending = 2'd1;
            partial = {16'd0, b[4:0]};
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            seq_len = 3'd3;
            pending = 2'd2;
            partial = {17'd0, b[3:0]};
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            seq_len = 3'd4;
            pending = 2'd3;
            partial = {18'd0, b[2:0]};
          end else begin
            state = ST_INVALID;
          end
        end else if (b[7:6] != 2'b10) begin
          state = ST_INVALID;
        end else begin
          partial = {partial[14:0], b[5:0]};
          pending = pending - 2'd1;
          if (pending == 2'd0) begin
            if ((seq_len == 3'd3 && partial < 21'h000800) ||
                (seq_len == 3'd4 && partial < 21'h010000) ||
                (partial >= 21'h00D800 && partial <= 21'h00DFFF) ||
                partial > 21'h10FFFF) begin
              state = ST_INVALID;
            end else begin
              count_codepoint();
            end
          end
        end
      end
      if (fin) begin
        if (state == ST_VALID && pending != 2'd0) state = ST_INVALID;
        verdict.status = state;
        verdict.count = count;
        expected.insert(expected.size(), verdict);
        clear_string();
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task match_result(logic [1:0] got_status, logic [COUNT_W-1:0] got_count);
      result_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result: status %0d count %0d", got_status, got_count));
      end else begin
        want = expected.pop_front();
        checked++;
        case (want.status)
          ST_VALID:    n_valid++;
          ST_INVALID:  n_invalid++;
          ST_TOO_MANY: n_too_many++;
          default: ;
        endcase
        if (got_status !== want.status)
          report($sformatf("string %0d: status %0d, expected %0d",
                           checked, got_status, want.status));
        if (got_count !== want.count)
          report($sformatf("string %0d: codepoint_count %0d, expected %0d",
                           checked, got_count, want.count));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                byte_present = 1'b0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [COUNT_W-1:0]  codepoint_count;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  max_codepoints = '0;

  utf8_verdicts sb;
  beat_t        str_beats[$];
  int           beats_sent = 0;
  int           cycles = 0;
  bit           in_calm = 1'b0;
  bit           out_calm = 1'b0;
  bit           hold_req = 1'b0;

  utf8_validator_with_codepoint_limit uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .byte_present    (byte_present),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .codepoint_count (codepoint_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .max_codepoints  (max_codepoints)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Values seen here are the ones from before the edge, so each handshake is counted once.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.match_result(status, codepoint_count);
      if (in_valid && in_ready) sb.take_beat(data_byte, byte_present, last);
    end
  end

  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = out_calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic void push_byte(logic [BYTE_W-1:0] b);
    beat_t bt;
    bt.data = b;
    bt.present = 1'b1;
    bt.fin = 1'b0;
    str_beats.insert(str_beats.size(), bt);
  endfunction

  function automatic void push_none();
    beat_t bt;
    bt.data = BYTE_W'($urandom_range(0, 255));
    bt.present = 1'b0;
    bt.fin = 1'b0;
    str_beats.insert(str_beats.size(), bt);
  endfunction

  // Mostly well-formed characters of every length; the rest are the usual ways to break one, or a beat with no byte.
  function automatic void add_char();
    int              pick;
    logic [20:0]     cp;
    logic [BYTE_W-1:0] junk;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(1, 4))
        1: begin
          cp = 21'($urandom_range(0, 'h7F));
          push_byte({1'b0, cp[6:0]});
        end
        2: begin
          cp = 21'($urandom_range('h80, 'h7FF));
          push_byte({3'b110, cp[10:6]});
          push_byte({2'b10, cp[5:0]});
        end
        3: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp + 21'h000800;
          push_byte({4'b1110, cp[15:12]});
          push_byte({2'b10, cp[11:6]});
          push_byte({2'b10, cp[5:0]});
        end
        default: begin
          cp = 21'($urandom_range('h10000, 'h10FFFF));
          push_byte({5'b11110, cp[20:18]});
          push_byte({2'b10, cp[17:12]});
          push_byte({2'b10, cp[11:6]});
          push_byte({2'b10, cp[5:0]});
        end
      endcase
    end else if (pick < 75) begin
      push_byte(BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      push_byte(BYTE_W'($urandom_range(0, 1) ? $urandom_range('h80, 'hC1)
                                             : $urandom_range('hF5, 'hFF)));
    end else if (pick < 85) begin
      push_byte(BYTE_W'($urandom_range('hC2, 'hF4)));
      junk = BYTE_W'($urandom_range(0, 255));
      if (junk[7:6] == 2'b10) junk[7] = 1'b0;
      push_byte(junk);
    end else if (pick < 89) begin
      if ($urandom_range(0, 1)) begin
        push_byte(8'hE0);
        push_byte(BYTE_W'($urandom_range('h80, 'h9F)));
      end else begin
        push_byte(8'hF0);
        push_byte(BYTE_W'($urandom_range('h80, 'h8F)));
        push_byte(BYTE_W'($urandom_range('h80, 'hBF)));
      end
      push_byte(BYTE_W'($urandom_range('h80, 'hBF)));
    end else if (pick < 93) begin
      push_byte(8'hED);
      push_byte(BYTE_W'($urandom_range('hA0, 'hBF)));
      push_byte(BYTE_W'($urandom_range('h80, 'hBF)));
    end else if (pick < 97) begin
      push_byte(8'hF4);
      push_byte(BYTE_W'($urandom_range('h90, 'hBF)));
      push_byte(BYTE_W'($urandom_range('h80, 'hBF)));
      push_byte(BYTE_W'($urandom_range('h80, 'hBF)));
    end else begin
      push_none();
    end
  endfunction

  task automatic send_beat(beat_t bt);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= bt.data;
    byte_present <= bt.present;
    last <= bt.fin;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Marks the final queued beat as the end of the string and sends the lot.
  task automatic send_queued();
    str_beats[str_beats.size()-1].fin = 1'b1;
    foreach (str_beats[i]) send_beat(str_beats[i]);
    str_beats.delete();
  endtask

  task automatic send_string(int n_chars);
    repeat (n_chars) add_char();
    // Dropping the tail byte often leaves a sequence cut short at the end.
    if (str_beats.size() != 0 && $urandom_range(0, 9) == 0) void'(str_beats.pop_back());
    if (str_beats.size() == 0 || $urandom_range(0, 7) == 0) push_none();
    send_queued();
  endtask

  task automatic run_phase(int n_beats, bit pressure);
    int target;
    target = beats_sent + n_beats;
    in_calm = pressure || ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    hold_req = pressure;
    while (beats_sent < target)
      send_string(($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6));
  endtask

  // Every string ends in a final beat, so wait for the last verdict and then a little more.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    max_codepoints <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.limit = value;
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_phase(150, 1'b0);
    settle();

    set_limit(24'd3);
    in_calm = 1'b0;
    push_none();
    send_queued();
    push_byte(8'h00); push_byte(8'hDF); push_byte(8'hBF); push_byte(8'h7F);
    send_queued();
    // The fourth codepoint crosses the limit of three.
    push_byte(8'h41); push_byte(8'h42); push_byte(8'h43);
    push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
    send_queued();
    // Overlong three-byte form; the byte after the error must be ignored.
    push_byte(8'hE0); push_byte(8'h80); push_byte(8'h80); push_byte(8'hFF);
    send_queued();
    push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80);
    send_queued();
    push_byte(8'hC2); push_byte(8'h41);
    send_queued();
    // Truncated four-byte sequence closed by beats without a byte.
    push_byte(8'hF0); push_byte(8'h90); push_none(); push_none();
    send_queued();
    settle();

    set_limit(24'd0);
    run_phase(210, 1'b0);
    settle();
    set_limit(24'd1);
    run_phase(210, 1'b1);
    settle();
    set_limit(24'hFFFFFF);
    run_phase(210, 1'b0);
    settle();
    set_limit(LIMIT_W'($urandom_range(2, 12)));
    run_phase(210, 1'b0);
    settle();
    set_limit(LIMIT_W'($urandom_range(0, 24'hFFFFFF)));
    run_phase(210, 1'b0);
    settle();

    $display("Checked %0d strings from %0d beats: %0d valid, %0d invalid, %0d over the limit.",
             sb.checked, beats_sent, sb.n_valid, sb.n_invalid, sb.n_too_many);
    $display("Limits covered reset value, 0, 1, 3, all ones and random; one long output stall.");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/utf8v_pkg.sv
src/utf8v_step.sv
src/utf8v_out_reg.sv
src/utf8_validator_with_codepoint_limit.sv
src/utf8v_checker.sv
dv/tb_utf8_validator_with_codepoint_limit.sv
